### hw/rtl/double_ended_queue_macros.svh
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("double_ended_queue: assertion failed");
`define DQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("double_ended_queue: implication failed");
`else
`define DQ_ASSERT(lbl, clk, rstn, prop)
`define DQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/dq_pkg.sv
// Types, constants and index helpers for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_EMIT
	} eng_state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} res_t;

	function automatic idx_t idx_inc(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic idx_t idx_dec(input idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic idx_t idx_add(input idx_t i, input cnt_t n);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(i) + (CNT_W + 1)'(n);
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(s);
	endfunction
endpackage

### hw/rtl/dq_front.sv
// Request intake: drops unknown opcodes and queues the rest for the engine.
`timescale 1ns / 1ps
module dq_front import dq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [2:0]              opcode,
	input  logic signed [VAL_W-1:0] push_value,
	output logic                    cmd_valid,
	output cmd_t                    cmd,
	input  logic                    cmd_take
);
	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       legal;
	logic       store;

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign legal     = (opcode <= 3'(OP_DUMP));
	assign store     = accept && legal;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (store) begin
			ent_q[wr_ptr_q] <= '{op: op_t'(opcode), value: push_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (store) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(store) - 2'(cmd_take);
		end
	end
endmodule

### hw/rtl/dq_back.sv
// Deque engine: ring store, head pointer, count, and the dump walker.
`timescale 1ns / 1ps
module dq_back import dq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	input  logic res_room,
	output logic res_valid,
	output res_t res,
	output cnt_t count
);
	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;
	eng_state_t state_q, state_d;
	idx_t head_q, head_d;
	cnt_t count_q, count_d;
	idx_t ptr_q, ptr_d;
	cnt_t rem_q, rem_d;
	logic wr_en, rd_en;
	idx_t wr_addr, rd_addr;
	logic go;
	logic is_full, is_empty;

	assign go       = cmd_valid && res_room && (state_q == ENG_IDLE);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign count    = count_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (go && !is_empty && (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK
						|| cmd.op == OP_DUMP)) begin
					state_d = ENG_EMIT;
				end
			end
			ENG_EMIT: begin
				if (res_room && rem_q == '0) begin
					state_d = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		cmd_take  = 1'b0;
		res_valid = 1'b0;
		res       = '{status: ST_OK, value: '0, last: 1'b1};
		wr_en     = 1'b0;
		wr_addr   = head_q;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		head_d    = head_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		rem_d     = rem_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (go) begin
					cmd_take = 1'b1;
					unique case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							res_valid = 1'b1;
							if (is_full) begin
								res.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
								if (cmd.op == OP_PUSH_FRONT) begin
									head_d  = idx_dec(head_q);
									wr_addr = idx_dec(head_q);
								end else begin
									wr_addr = idx_add(head_q, count_q);
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (is_empty) begin
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								count_d = count_q - 1'b1;
								rem_d   = '0;
								if (cmd.op == OP_POP_FRONT) begin
									head_d = idx_inc(head_q);
								end else begin
									rd_addr = idx_add(head_q, count_q - 1'b1);
								end
							end
						end
						OP_DUMP: begin
							if (is_empty) begin
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								rd_en = 1'b1;
								ptr_d = head_q;
								rem_d = count_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ENG_EMIT: begin
				if (res_room) begin
					res_valid = 1'b1;
					res.value = rd_data_q;
					res.last  = (rem_q == '0);
					if (rem_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = idx_inc(ptr_q);
						ptr_d   = idx_inc(ptr_q);
						rem_d   = rem_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			head_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			rem_q   <= rem_d;
		end
	end
endmodule

### hw/rtl/dq_out.sv
// Two-word result queue that parts the engine from the result ports.
`timescale 1ns / 1ps
module dq_out import dq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    res_valid,
	input  res_t                    res,
	output logic                    res_room,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] item_value,
	output logic                    last
);
	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       take;
	res_t       head;

	assign res_room   = (cnt_q != 2'd2);
	assign empty      = (cnt_q == 2'd0);
	assign take       = pop && !empty;
	assign head       = ent_q[rd_ptr_q];
	assign status     = head.status;
	assign item_value = head.value;
	assign last       = head.last;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			ent_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(res_valid) - 2'(take);
		end
	end
endmodule

### hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Requests enter a two-word intake queue; opcodes above dump are dropped
// there and give no result. The engine serves one request at a time: a push,
// or a pop or dump of an empty queue, gives its result in the cycle that the
// request is taken; a pop of a stored element reads the ring store, which has
// one registered read port, and gives its result from the emit state; a dump
// reads the stored elements front to back through that same port, one per
// result. Results leave through a two-word queue, so the engine keeps working
// while fewer than two results wait to be taken and stalls while two wait.
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"
module double_ended_queue import dq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [2:0]              opcode,
	input  logic signed [VAL_W-1:0] push_value,
	output logic                    empty,
	input  logic                    pop,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] item_value,
	output logic                    last
);
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic res_room;
	logic res_valid;
	res_t res;
	cnt_t count;

	dq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.push_value (push_value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	dq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_room  (res_room),
		.res_valid (res_valid),
		.res       (res),
		.count     (count)
	);

	dq_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.res_room   (res_room),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.item_value (item_value),
		.last       (last)
	);

	`DQ_ASSERT(a_count_bound, clk, arst_n, count <= CNT_W'(DEPTH))
	`DQ_ASSERT_IMPL(a_res_room, clk, arst_n, res_valid, res_room)
	`DQ_ASSERT_IMPL(a_cmd_take, clk, arst_n, cmd_take, cmd_valid)
	`DQ_ASSERT_IMPL(a_status_legal, clk, arst_n, !empty, status != 2'd3)
endmodule
